### rtl/core/lbmp_pkg.sv
// Shared types, constants and tables for the lidar beam to map point block.
// Used by lbmp_ctrl, lbmp_dp and lidar_beam_to_map_point; depends on nothing.
`default_nettype none
package lbmp_pkg;

  localparam int MaxBeams    = 4096;
  localparam int CordicSteps = 16;
  localparam int IterW       = (CordicSteps > 1) ? $clog2(CordicSteps) : 1;

  localparam int InDataW  = 176;
  localparam int OutDataW = 48;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgLaserOffX  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgLaserOffY  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgLaserYaw   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgMinFilter  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgMaxRange   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgAngleStart = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgAngleStep  = 3'd6;

  // item kinds
  localparam logic FuncPose = 1'b0;
  localparam logic FuncBeam = 1'b1;

  // datapath actions
  localparam logic [3:0] ActNone     = 4'd0;
  localparam logic [3:0] ActLoad     = 4'd1;
  localparam logic [3:0] ActNum      = 4'd2;
  localparam logic [3:0] ActVecInit  = 4'd3;
  localparam logic [3:0] ActVecIter  = 4'd4;
  localparam logic [3:0] ActRotPose  = 4'd5;
  localparam logic [3:0] ActRotBeam  = 4'd6;
  localparam logic [3:0] ActRotIter  = 4'd7;
  localparam logic [3:0] ActRotFin   = 4'd8;
  localparam logic [3:0] ActPoseDone = 4'd9;
  localparam logic [3:0] ActLx       = 4'd10;
  localparam logic [3:0] ActLy       = 4'd11;
  localparam logic [3:0] ActMx       = 4'd12;
  localparam logic [3:0] ActOut      = 4'd13;

  // multiplier operand pairs
  localparam logic [3:0] MulWz  = 4'd0;
  localparam logic [3:0] MulXy  = 4'd1;
  localparam logic [3:0] MulWw  = 4'd2;
  localparam logic [3:0] MulXx  = 4'd3;
  localparam logic [3:0] MulYy  = 4'd4;
  localparam logic [3:0] MulZz  = 4'd5;
  localparam logic [3:0] MulIdx = 4'd6;
  localparam logic [3:0] MulRc  = 4'd7;
  localparam logic [3:0] MulRs  = 4'd8;
  localparam logic [3:0] MulLxc = 4'd9;
  localparam logic [3:0] MulLys = 4'd10;
  localparam logic [3:0] MulLxs = 4'd11;
  localparam logic [3:0] MulLyc = 4'd12;

  // accumulator operations
  localparam logic [1:0] AccHold = 2'd0;
  localparam logic [1:0] AccLoad = 2'd1;
  localparam logic [1:0] AccAdd  = 2'd2;
  localparam logic [1:0] AccSub  = 2'd3;

  typedef struct packed {
    logic [3:0]       act;
    logic [3:0]       mul_sel;
    logic [1:0]       acc_op;
    logic [IterW-1:0] iter;
  } cmd_t;

  typedef struct packed {
    logic drop;
    logic out_busy;
  } status_t;

  // atan(2^-i) in turns*2^24
  function automatic logic [21:0] atan_lut(input logic [4:0] i);
    logic [21:0] v;
    case (i)
      5'd0:  v = 22'd2097152;
      5'd1:  v = 22'd1238021;
      5'd2:  v = 22'd654136;
      5'd3:  v = 22'd332050;
      5'd4:  v = 22'd166669;
      5'd5:  v = 22'd83416;
      5'd6:  v = 22'd41718;
      5'd7:  v = 22'd20860;
      5'd8:  v = 22'd10430;
      5'd9:  v = 22'd5215;
      5'd10: v = 22'd2608;
      5'd11: v = 22'd1304;
      5'd12: v = 22'd652;
      5'd13: v = 22'd326;
      5'd14: v = 22'd163;
      5'd15: v = 22'd81;
      5'd16: v = 22'd41;
      5'd17: v = 22'd20;
      5'd18: v = 22'd10;
      5'd19: v = 22'd5;
      5'd20: v = 22'd3;
      5'd21: v = 22'd1;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### rtl/core/lbmp_ctrl.sv
// Sequencer for the lidar beam to map point block: steps the shared multiplier
// and CORDIC through pose and beam work. Depends on lbmp_pkg.
`default_nettype none
module lbmp_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             in_func_i,
  output logic                  in_ready_o,
  input  wire lbmp_pkg::status_t status_i,
  output lbmp_pkg::cmd_t        cmd_o
);

  localparam logic [4:0] SIdle  = 5'd0;
  localparam logic [4:0] SP1    = 5'd1;
  localparam logic [4:0] SP2    = 5'd2;
  localparam logic [4:0] SP3    = 5'd3;
  localparam logic [4:0] SP4    = 5'd4;
  localparam logic [4:0] SP5    = 5'd5;
  localparam logic [4:0] SP6    = 5'd6;
  localparam logic [4:0] SP7    = 5'd7;
  localparam logic [4:0] SVInit = 5'd8;
  localparam logic [4:0] SVIter = 5'd9;
  localparam logic [4:0] SRPose = 5'd10;
  localparam logic [4:0] SRIter = 5'd11;
  localparam logic [4:0] SRFin  = 5'd12;
  localparam logic [4:0] SPDone = 5'd13;
  localparam logic [4:0] SB0    = 5'd14;
  localparam logic [4:0] SB1    = 5'd15;
  localparam logic [4:0] SRBeam = 5'd16;
  localparam logic [4:0] SM1    = 5'd17;
  localparam logic [4:0] SM2    = 5'd18;
  localparam logic [4:0] SM3    = 5'd19;
  localparam logic [4:0] SM4    = 5'd20;
  localparam logic [4:0] SM5    = 5'd21;
  localparam logic [4:0] SM6    = 5'd22;
  localparam logic [4:0] SM7    = 5'd23;
  localparam logic [4:0] SM8    = 5'd24;
  localparam logic [4:0] SOut   = 5'd25;

  localparam logic [lbmp_pkg::IterW-1:0] IterLast =
    lbmp_pkg::IterW'(lbmp_pkg::CordicSteps - 1);

  logic [4:0]                  state_q, state_d;
  logic [lbmp_pkg::IterW-1:0]  iter_q, iter_d;
  logic                        beam_q, beam_d;

  assign in_ready_o = (state_q == SIdle);

  always_comb begin
    state_d        = state_q;
    iter_d         = iter_q;
    beam_d         = beam_q;
    cmd_o.act      = lbmp_pkg::ActNone;
    cmd_o.mul_sel  = lbmp_pkg::MulWz;
    cmd_o.acc_op   = lbmp_pkg::AccHold;
    cmd_o.iter     = iter_q;
    case (state_q)
      SIdle: begin
        iter_d = '0;
        if (in_valid_i) begin
          cmd_o.act = lbmp_pkg::ActLoad;
          beam_d    = (in_func_i == lbmp_pkg::FuncBeam);
          state_d   = (in_func_i == lbmp_pkg::FuncBeam) ? SB0 : SP1;
        end
      end
      SP1: begin
        cmd_o.mul_sel = lbmp_pkg::MulWz;
        state_d = SP2;
      end
      SP2: begin
        cmd_o.mul_sel = lbmp_pkg::MulXy;
        cmd_o.acc_op  = lbmp_pkg::AccLoad;
        state_d = SP3;
      end
      SP3: begin
        cmd_o.mul_sel = lbmp_pkg::MulWw;
        cmd_o.acc_op  = lbmp_pkg::AccAdd;
        state_d = SP4;
      end
      SP4: begin
        cmd_o.mul_sel = lbmp_pkg::MulXx;
        cmd_o.acc_op  = lbmp_pkg::AccLoad;
        cmd_o.act     = lbmp_pkg::ActNum;
        state_d = SP5;
      end
      SP5: begin
        cmd_o.mul_sel = lbmp_pkg::MulYy;
        cmd_o.acc_op  = lbmp_pkg::AccAdd;
        state_d = SP6;
      end
      SP6: begin
        cmd_o.mul_sel = lbmp_pkg::MulZz;
        cmd_o.acc_op  = lbmp_pkg::AccSub;
        state_d = SP7;
      end
      SP7: begin
        cmd_o.acc_op = lbmp_pkg::AccSub;
        state_d = SVInit;
      end
      SVInit: begin
        cmd_o.act = lbmp_pkg::ActVecInit;
        state_d = SVIter;
      end
      SVIter: begin
        cmd_o.act = lbmp_pkg::ActVecIter;
        iter_d = iter_q + 1'b1;
        if (iter_q == IterLast) begin
          iter_d  = '0;
          state_d = SRPose;
        end
      end
      SRPose: begin
        cmd_o.act = lbmp_pkg::ActRotPose;
        state_d = SRIter;
      end
      SRIter: begin
        cmd_o.act = lbmp_pkg::ActRotIter;
        iter_d = iter_q + 1'b1;
        if (iter_q == IterLast) begin
          iter_d  = '0;
          state_d = SRFin;
        end
      end
      SRFin: begin
        cmd_o.act = lbmp_pkg::ActRotFin;
        state_d = beam_q ? SM1 : SPDone;
      end
      SPDone: begin
        cmd_o.act = lbmp_pkg::ActPoseDone;
        state_d = SIdle;
      end
      SB0: begin
        cmd_o.mul_sel = lbmp_pkg::MulIdx;
        state_d = status_i.drop ? SIdle : SB1;
      end
      SB1: begin
        cmd_o.acc_op = lbmp_pkg::AccLoad;
        state_d = SRBeam;
      end
      SRBeam: begin
        cmd_o.act = lbmp_pkg::ActRotBeam;
        state_d = SRIter;
      end
      SM1: begin
        cmd_o.mul_sel = lbmp_pkg::MulRc;
        state_d = SM2;
      end
      SM2: begin
        cmd_o.mul_sel = lbmp_pkg::MulRs;
        cmd_o.acc_op  = lbmp_pkg::AccLoad;
        state_d = SM3;
      end
      SM3: begin
        cmd_o.act    = lbmp_pkg::ActLx;
        cmd_o.acc_op = lbmp_pkg::AccLoad;
        state_d = SM4;
      end
      SM4: begin
        cmd_o.act     = lbmp_pkg::ActLy;
        cmd_o.mul_sel = lbmp_pkg::MulLxc;
        state_d = SM5;
      end
      SM5: begin
        cmd_o.mul_sel = lbmp_pkg::MulLys;
        cmd_o.acc_op  = lbmp_pkg::AccLoad;
        state_d = SM6;
      end
      SM6: begin
        cmd_o.mul_sel = lbmp_pkg::MulLxs;
        cmd_o.acc_op  = lbmp_pkg::AccSub;
        state_d = SM7;
      end
      SM7: begin
        cmd_o.mul_sel = lbmp_pkg::MulLyc;
        cmd_o.act     = lbmp_pkg::ActMx;
        cmd_o.acc_op  = lbmp_pkg::AccLoad;
        state_d = SM8;
      end
      SM8: begin
        cmd_o.acc_op = lbmp_pkg::AccAdd;
        state_d = SOut;
      end
      SOut: begin
        // hold until the previous result beat has left
        if (!status_i.out_busy) begin
          cmd_o.act = lbmp_pkg::ActOut;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      iter_q  <= '0;
      beam_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
      beam_q  <= beam_d;
    end
  end

endmodule
`default_nettype wire

### rtl/core/lbmp_dp.sv
// Datapath for the lidar beam to map point block: configuration and pose
// registers, shared multiplier with accumulator, shared CORDIC. Depends on lbmp_pkg.
`default_nettype none
module lbmp_dp (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [lbmp_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [lbmp_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire logic [lbmp_pkg::InDataW-1:0]    in_data_i,
  output logic [lbmp_pkg::OutDataW-1:0]        out_data_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  input  wire lbmp_pkg::cmd_t                  cmd_i,
  output lbmp_pkg::status_t                    status_o
);

  localparam logic signed [35:0] RotX0     = 36'sd163008219;
  localparam logic signed [24:0] QuarterT  = 25'sd4194304;
  localparam logic signed [24:0] HalfT     = 25'sd8388608;

  // configuration
  logic [23:0] off_x_q, off_y_q, off_yaw_q, ang_start_q, ang_step_q;
  logic [15:0] min_filt_q, max_range_q;

  // pose state
  logic               pose_valid_q;
  logic signed [23:0] robot_x_q, robot_y_q;
  logic signed [15:0] yaw_cos_q, yaw_sin_q;

  // latched item
  logic [lbmp_pkg::InDataW-1:0] item_q;
  logic [15:0]        f_range, f_rmin, f_rmax;
  logic               f_finite;
  logic [11:0]        f_idx;
  logic signed [15:0] f_qx, f_qy, f_qz, f_qw;

  assign f_range  = item_q[15:0];
  assign f_finite = item_q[16];
  assign f_idx    = item_q[28:17];
  assign f_rmin   = item_q[44:29];
  assign f_rmax   = item_q[60:45];
  assign f_qx     = item_q[124:109];
  assign f_qy     = item_q[140:125];
  assign f_qz     = item_q[156:141];
  assign f_qw     = item_q[172:157];

  // range filter
  logic [16:0] lo_lim;
  logic [15:0] hi_lim;
  logic        drop;
  always_comb begin
    lo_lim = {1'b0, f_rmin} + {1'b0, min_filt_q};
    hi_lim = (f_rmax < max_range_q) ? f_rmax : max_range_q;
    drop   = !pose_valid_q || !f_finite || ({1'b0, f_range} < lo_lim) ||
             (f_range > hi_lim) || (32'(f_idx) >= 32'(lbmp_pkg::MaxBeams));
  end

  // multiplier and accumulator
  logic signed [39:0] ma;
  logic signed [17:0] mb;
  logic signed [57:0] prod_q, acc_q;
  logic signed [16:0] c_q, s_q;
  logic signed [39:0] lx_q, ly_q;
  logic signed [29:0] mx_q;

  always_comb begin
    ma = 40'sd0;
    mb = 18'sd0;
    case (cmd_i.mul_sel)
      lbmp_pkg::MulWz:  begin ma = 40'(f_qw); mb = 18'(f_qz); end
      lbmp_pkg::MulXy:  begin ma = 40'(f_qx); mb = 18'(f_qy); end
      lbmp_pkg::MulWw:  begin ma = 40'(f_qw); mb = 18'(f_qw); end
      lbmp_pkg::MulXx:  begin ma = 40'(f_qx); mb = 18'(f_qx); end
      lbmp_pkg::MulYy:  begin ma = 40'(f_qy); mb = 18'(f_qy); end
      lbmp_pkg::MulZz:  begin ma = 40'(f_qz); mb = 18'(f_qz); end
      lbmp_pkg::MulIdx: begin
        ma = 40'($signed(ang_step_q));
        mb = $signed({6'd0, f_idx});
      end
      lbmp_pkg::MulRc:  begin ma = $signed({24'd0, f_range}); mb = 18'(c_q); end
      lbmp_pkg::MulRs:  begin ma = $signed({24'd0, f_range}); mb = 18'(s_q); end
      lbmp_pkg::MulLxc: begin ma = lx_q; mb = 18'(yaw_cos_q); end
      lbmp_pkg::MulLys: begin ma = ly_q; mb = 18'(yaw_sin_q); end
      lbmp_pkg::MulLxs: begin ma = lx_q; mb = 18'(yaw_sin_q); end
      lbmp_pkg::MulLyc: begin ma = ly_q; mb = 18'(yaw_cos_q); end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 58'(ma * mb);
    case (cmd_i.acc_op)
      lbmp_pkg::AccLoad: acc_q <= prod_q;
      lbmp_pkg::AccAdd:  acc_q <= acc_q + prod_q;
      lbmp_pkg::AccSub:  acc_q <= acc_q - prod_q;
      default: ;
    endcase
  end

  // CORDIC, one step a cycle
  logic signed [35:0] cx_q, cy_q, xs, ys;
  logic signed [25:0] cz_q, atn;
  logic               neg_q, zero_q, dir;
  logic [23:0]        rot_ang;
  logic signed [24:0] ra;
  logic signed [21:0] cfx, cfy;

  always_comb begin
    xs  = cx_q >>> cmd_i.iter;
    ys  = cy_q >>> cmd_i.iter;
    atn = $signed({4'd0, lbmp_pkg::atan_lut(5'(cmd_i.iter))});
    dir = (cmd_i.act == lbmp_pkg::ActVecIter) ? cy_q[35] : !cz_q[25];
    if (cmd_i.act == lbmp_pkg::ActRotPose) begin
      rot_ang = zero_q ? 24'd0 : cz_q[23:0];
    end else begin
      rot_ang = ang_start_q + acc_q[23:0] + off_yaw_q;
    end
    ra = 25'($signed(rot_ang));
    cfx = 22'((cx_q + 36'sd8192) >>> 14);
    cfy = 22'((cy_q + 36'sd8192) >>> 14);
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.act)
      lbmp_pkg::ActNum: cy_q <= 36'(acc_q) <<< 1;
      lbmp_pkg::ActVecInit: begin
        zero_q <= (acc_q == 58'sd0) && (cy_q == 36'sd0);
        if (acc_q[57]) begin
          cx_q <= -36'(acc_q);
          cy_q <= -cy_q;
          cz_q <= 26'(HalfT);
        end else begin
          cx_q <= 36'(acc_q);
          cz_q <= 26'sd0;
        end
      end
      lbmp_pkg::ActVecIter, lbmp_pkg::ActRotIter: begin
        if (dir) begin
          cx_q <= cx_q - ys;
          cy_q <= cy_q + xs;
          cz_q <= cz_q - atn;
        end else begin
          cx_q <= cx_q + ys;
          cy_q <= cy_q - xs;
          cz_q <= cz_q + atn;
        end
      end
      lbmp_pkg::ActRotPose, lbmp_pkg::ActRotBeam: begin
        cx_q <= RotX0;
        cy_q <= 36'sd0;
        // fold into the right half plane, flip the result back later
        if (ra > QuarterT) begin
          cz_q  <= 26'(ra - HalfT);
          neg_q <= 1'b1;
        end else if (ra < -QuarterT) begin
          cz_q  <= 26'(ra + HalfT);
          neg_q <= 1'b1;
        end else begin
          cz_q  <= 26'(ra);
          neg_q <= 1'b0;
        end
      end
      lbmp_pkg::ActRotFin: begin
        c_q <= neg_q ? -17'(cfx) : 17'(cfx);
        s_q <= neg_q ? -17'(cfy) : 17'(cfy);
      end
      lbmp_pkg::ActLx: lx_q <= 40'(acc_q) + (40'($signed(off_x_q)) <<< 14);
      lbmp_pkg::ActLy: ly_q <= 40'(acc_q) + (40'($signed(off_y_q)) <<< 14);
      lbmp_pkg::ActMx: mx_q <= 30'((acc_q + 58'sd134217728) >>> 28);
      default: ;
    endcase
    if (cmd_i.act == lbmp_pkg::ActLoad) begin
      item_q <= in_data_i;
    end
  end

  // saturated result
  logic signed [29:0] my;
  logic signed [30:0] sum_x, sum_y;
  logic signed [23:0] sat_x, sat_y;
  always_comb begin
    my    = 30'((acc_q + 58'sd134217728) >>> 28);
    sum_x = 31'(mx_q) + 31'(robot_x_q);
    sum_y = 31'(my) + 31'(robot_y_q);
    if (sum_x > 31'sd8388607)       sat_x = 24'sh7FFFFF;
    else if (sum_x < -31'sd8388608) sat_x = 24'sh800000;
    else                            sat_x = 24'(sum_x);
    if (sum_y > 31'sd8388607)       sat_y = 24'sh7FFFFF;
    else if (sum_y < -31'sd8388608) sat_y = 24'sh800000;
    else                            sat_y = 24'(sum_y);
  end

  logic                               out_valid_q;
  logic [lbmp_pkg::OutDataW-1:0]      out_data_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign status_o    = '{drop: drop, out_busy: out_valid_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.act == lbmp_pkg::ActOut) begin
      out_data_q <= {sat_y, sat_x};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pose_valid_q <= 1'b0;
      robot_x_q    <= '0;
      robot_y_q    <= '0;
      yaw_cos_q    <= 16'sd16384;
      yaw_sin_q    <= '0;
      off_x_q      <= '0;
      off_y_q      <= '0;
      off_yaw_q    <= 24'd333772;
      min_filt_q   <= 16'd256;
      max_range_q  <= 16'd10240;
      ang_start_q  <= '0;
      ang_step_q   <= '0;
    end else begin
      if (cmd_i.act == lbmp_pkg::ActOut) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.act == lbmp_pkg::ActPoseDone) begin
        pose_valid_q <= 1'b1;
        robot_x_q    <= item_q[84:61];
        robot_y_q    <= item_q[108:85];
        yaw_cos_q    <= 16'(c_q);
        yaw_sin_q    <= 16'(s_q);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          lbmp_pkg::CfgLaserOffX:  off_x_q     <= cfg_data_i;
          lbmp_pkg::CfgLaserOffY:  off_y_q     <= cfg_data_i;
          lbmp_pkg::CfgLaserYaw:   off_yaw_q   <= cfg_data_i;
          lbmp_pkg::CfgMinFilter:  min_filt_q  <= cfg_data_i[15:0];
          lbmp_pkg::CfgMaxRange:   max_range_q <= cfg_data_i[15:0];
          lbmp_pkg::CfgAngleStart: ang_start_q <= cfg_data_i;
          lbmp_pkg::CfgAngleStep:  ang_step_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/lidar_beam_to_map_point.sv
// Lidar beam to map point, one item at a time. A pose update keeps the input busy
// through the quaternion products and both CORDIC passes; a beam puts its result beat
// in the output register after the CORDIC rotation and the multiplier steps, later
// while the previous result still waits there. The 16-step CORDIC and the shared
// multiplier do this work. A dropped beam frees the input in the cycle after acceptance.
// Reset (rst_ni, async, low) clears the pose and loads configuration defaults.
`default_nettype none
module lidar_beam_to_map_point (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [lbmp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [lbmp_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // beam_range, range_finite, beam_index, scan_range_min, scan_range_max,
  // pose_x, pose_y, quat_x, quat_y, quat_z, quat_w, zero fill
  input  wire logic [lbmp_pkg::InDataW-1:0]   s_axis_tdata,
  // func
  input  wire logic                           s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // map_x, map_y
  output logic [lbmp_pkg::OutDataW-1:0]       m_axis_tdata
);

  lbmp_pkg::cmd_t    cmd;
  lbmp_pkg::status_t status;

  lbmp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_func_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lbmp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .out_data_o  (m_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule
`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for lidar_beam_to_map_point: directed and random pose and
// beam beats, with a predictor of the CORDIC datapath. Depends on rtl lbmp_pkg.
`timescale 1ns / 1ps
module testbench;

  typedef struct {
    logic        func;
    logic [15:0] rng;
    logic        fin;
    logic [11:0] idx;
    logic [15:0] rmin;
    logic [15:0] rmax;
    logic [23:0] px;
    logic [23:0] py;
    logic [15:0] qx;
    logic [15:0] qy;
    logic [15:0] qz;
    logic [15:0] qw;
  } scan_beat_t;

  typedef struct {
    logic [23:0] mx;
    logic [23:0] my;
  } map_point_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [lbmp_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [lbmp_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [lbmp_pkg::InDataW-1:0]  s_axis_tdata = '0;
  logic                          s_axis_tuser = 1'b0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [lbmp_pkg::OutDataW-1:0] m_axis_tdata;

  lidar_beam_to_map_point dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // atan(2^-i), turns*2^24
  localparam longint AtanTurns [0:15] = '{2097152, 1238021, 654136, 332050, 166669,
    83416, 41718, 20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

  // predictor copies of configuration and pose
  logic [23:0] off_x, off_y, off_yaw, ang_start, ang_step;
  logic [15:0] min_filt, max_rng;
  logic        have_pose;
  longint      rob_x, rob_y, head_cos, head_sin;

  scan_beat_t  pending_q[$];
  map_point_t  points_q[$];
  int          n_queued, n_taken, n_errors, idle_cycles;
  int          rx_wait, tx_wait, hold_left, hold_req, hold_seen;
  bit          no_idle;

  // taken flag: beat on the input was accepted at the last rising edge
  logic s_axis_tready_q = 1'b0;
  scan_beat_t shadow_q[$];

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  function automatic void cos_sin(input logic [23:0] ang, output longint c, output longint s);
    longint a, x, y, z, dx, dy;
    bit     flip;
    a = longint'(signed'(ang));
    flip = 1'b0;
    x = 163008219;
    y = 0;
    if (a > 4194304) begin
      a -= 8388608; flip = 1'b1;
    end else if (a < -4194304) begin
      a += 8388608; flip = 1'b1;
    end
    z = a;
    for (int i = 0; i < lbmp_pkg::CordicSteps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= AtanTurns[i];
      end else begin
        x += dx; y -= dy; z += AtanTurns[i];
      end
    end
    x = (x + 8192) >>> 14;
    y = (y + 8192) >>> 14;
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic [23:0] heading(input longint yy, input longint xx);
    longint x, y, z, dx, dy;
    x = xx; y = yy; z = 0;
    if (x == 0 && y == 0) return 24'd0;
    if (x < 0) begin
      x = -x; y = -y; z = 8388608;
    end
    for (int i = 0; i < lbmp_pkg::CordicSteps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y < 0) begin
        x -= dx; y += dy; z -= AtanTurns[i];
      end else begin
        x += dx; y -= dy; z += AtanTurns[i];
      end
    end
    return z[23:0];
  endfunction

  function automatic logic [23:0] clamp24(input longint v);
    if (v > 8388607) return 24'h7FFFFF;
    if (v < -8388608) return 24'h800000;
    return v[23:0];
  endfunction

  // update pose state or compute the map point; returns 1 when a point results
  function automatic bit predict_point(input scan_beat_t b, output map_point_t p);
    longint qx, qy, qz, qw, c, s, lx, ly, r;
    logic [16:0] lo;
    logic [15:0] lim;
    logic [23:0] ang;
    p = '{default: '0};
    if (b.func == lbmp_pkg::FuncPose) begin
      qx = longint'(signed'(b.qx)); qy = longint'(signed'(b.qy));
      qz = longint'(signed'(b.qz)); qw = longint'(signed'(b.qw));
      cos_sin(heading(2 * (qw * qz + qx * qy), qw * qw + qx * qx - qy * qy - qz * qz),
              head_cos, head_sin);
      rob_x = longint'(signed'(b.px));
      rob_y = longint'(signed'(b.py));
      have_pose = 1'b1;
      return 1'b0;
    end
    lo = {1'b0, b.rmin} + {1'b0, min_filt};
    lim = (b.rmax < max_rng) ? b.rmax : max_rng;
    if (!have_pose || !b.fin || {1'b0, b.rng} < lo || b.rng > lim) return 1'b0;
    if (int'(b.idx) >= lbmp_pkg::MaxBeams) return 1'b0;
    ang = ang_start + 24'(b.idx) * ang_step + off_yaw;
    cos_sin(ang, c, s);
    r = longint'(b.rng);
    lx = r * c + longint'(signed'(off_x)) * 16384;
    ly = r * s + longint'(signed'(off_y)) * 16384;
    p.mx = clamp24(((lx * head_cos - ly * head_sin + (64'sd1 <<< 27)) >>> 28) + rob_x);
    p.my = clamp24(((lx * head_sin + ly * head_cos + (64'sd1 <<< 27)) >>> 28) + rob_y);
    return 1'b1;
  endfunction

  function automatic logic [lbmp_pkg::InDataW-1:0] pack_beat(input scan_beat_t b);
    return lbmp_pkg::InDataW'({b.qw, b.qz, b.qy, b.qx, b.py, b.px, b.rmax, b.rmin, b.idx,
                               b.fin, b.rng});
  endfunction

  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, signed'(got),
             signed'(want), $realtime);
    n_errors++;
  endtask

  // driver: present beats at the falling edge, with random gaps unless no_idle is set
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || s_axis_tready_q)) begin
      if (tx_wait > 0) begin
        tx_wait <= tx_wait - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        s_axis_tdata <= pack_beat(pending_q[0]);
        s_axis_tuser <= pending_q[0].func;
        s_axis_tvalid <= 1'b1;
        void'(pending_q.pop_front());
        tx_wait <= no_idle ? 0 : pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold on request
  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 600;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // monitor: predict on input beats, check output beats
  always @(posedge clk_i) begin
    map_point_t p, want;
    s_axis_tready_q <= s_axis_tvalid && s_axis_tready;
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (predict_point(shadow_q.pop_front(), p)) points_q.insert(points_q.size(), p);
        n_taken <= n_taken + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        rx_wait <= no_idle ? 0 : pick_gap();
        if (points_q.size() == 0) begin
          report_mismatch("unexpected map point x", m_axis_tdata[23:0], 24'd0);
        end else begin
          want = points_q.pop_front();
          if (m_axis_tdata[23:0] !== want.mx)
            report_mismatch("map_x", m_axis_tdata[23:0], want.mx);
          if (m_axis_tdata[47:24] !== want.my)
            report_mismatch("map_y", m_axis_tdata[47:24], want.my);
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  task automatic queue_beat(input scan_beat_t b);
    pending_q.insert(pending_q.size(), b);
    shadow_q.insert(shadow_q.size(), b);
    n_queued++;
  endtask

  task automatic write_reg(input logic [lbmp_pkg::CfgIdxW-1:0] idx, input logic [23:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      lbmp_pkg::CfgLaserOffX:  off_x = val;
      lbmp_pkg::CfgLaserOffY:  off_y = val;
      lbmp_pkg::CfgLaserYaw:   off_yaw = val;
      lbmp_pkg::CfgMinFilter:  min_filt = val[15:0];
      lbmp_pkg::CfgMaxRange:   max_rng = val[15:0];
      lbmp_pkg::CfgAngleStart: ang_start = val;
      lbmp_pkg::CfgAngleStep:  ang_step = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (n_taken != n_queued || points_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic scan_beat_t any_beat();
    scan_beat_t b;
    b.func = 1'($urandom_range(0, 1));
    b.rng = 16'($urandom); b.fin = 1'($urandom); b.idx = 12'($urandom);
    b.rmin = 16'($urandom); b.rmax = 16'($urandom);
    b.px = 24'($urandom); b.py = 24'($urandom);
    b.qx = 16'($urandom); b.qy = 16'($urandom); b.qz = 16'($urandom); b.qw = 16'($urandom);
    return b;
  endfunction

  function automatic scan_beat_t pose_beat(input int px, input int py, input int qx,
                                           input int qy, input int qz, input int qw);
    scan_beat_t b;
    b = any_beat();
    b.func = lbmp_pkg::FuncPose;
    b.px = 24'(px); b.py = 24'(py);
    b.qx = 16'(qx); b.qy = 16'(qy); b.qz = 16'(qz); b.qw = 16'(qw);
    return b;
  endfunction

  function automatic scan_beat_t beam_beat(input int rng, input bit fin, input int idx,
                                           input int rmin, input int rmax);
    scan_beat_t b;
    b = any_beat();
    b.func = lbmp_pkg::FuncBeam;
    b.rng = 16'(rng); b.fin = fin; b.idx = 12'(idx);
    b.rmin = 16'(rmin); b.rmax = 16'(rmax);
    return b;
  endfunction

  // a beam that passes the range filter when the filter allows it
  function automatic scan_beat_t good_beam();
    int rmin, rmax, lo, hi;
    rmin = $urandom_range(0, 2000);
    rmax = $urandom_range(0, 65535);
    lo = rmin + int'(min_filt);
    hi = (rmax < int'(max_rng)) ? rmax : int'(max_rng);
    return beam_beat((lo <= hi) ? $urandom_range(lo, hi) : $urandom_range(0, 65535), 1'b1,
                     $urandom_range(0, 4095), rmin, rmax);
  endfunction

  initial begin
    int lo;
    logic [23:0] cfg_val [7];
    n_queued = 0; n_taken = 0; n_errors = 0;
    rx_wait = 0; tx_wait = 0; hold_left = 0; hold_req = 0; hold_seen = 0; no_idle = 0;
    off_x = 0; off_y = 0; off_yaw = 24'd333772; min_filt = 16'd256; max_rng = 16'd10240;
    ang_start = 0; ang_step = 0;
    have_pose = 1'b0; rob_x = 0; rob_y = 0; head_cos = 16384; head_sin = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset configuration
    queue_beat(beam_beat(1000, 1'b1, 0, 0, 20000));
    queue_beat(pose_beat(0, 0, 0, 0, 0, 0));
    queue_beat(beam_beat(1000, 1'b1, 0, 0, 20000));
    queue_beat(pose_beat(8388607, -8388608, 0, 0, 11585, 11585));
    lo = 100 + 256;
    queue_beat(beam_beat(lo, 1'b1, 5, 100, 65535));
    queue_beat(beam_beat(lo - 1, 1'b1, 5, 100, 65535));
    queue_beat(beam_beat(10240, 1'b1, 4095, 0, 65535));
    queue_beat(beam_beat(10241, 1'b1, 7, 0, 65535));
    queue_beat(beam_beat(3000, 1'b1, 7, 0, 3000));
    queue_beat(beam_beat(3001, 1'b1, 7, 0, 3000));
    queue_beat(beam_beat(5000, 1'b0, 7, 0, 65535));
    queue_beat(beam_beat(0, 1'b1, 0, 0, 65535));
    queue_beat(beam_beat(65535, 1'b1, 0, 65535, 65535));
    queue_beat(pose_beat(-8388608, 8388607, -32768, -32768, -32768, -32768));
    queue_beat(beam_beat(9000, 1'b1, 100, 0, 65535));
    queue_beat(pose_beat(12345, -54321, 32767, 32767, 32767, 32767));
    queue_beat(beam_beat(9000, 1'b1, 2048, 0, 65535));
    queue_beat(pose_beat(-1000, 2000, 0, 0, 16384, 0));
    queue_beat(beam_beat(600, 1'b1, 1, 0, 65535));
    queue_beat(pose_beat(0, 0, 0, 0, -16384, 16384));
    queue_beat(beam_beat(10000, 1'b1, 3, 0, 65535));
    wait_drained();

    for (int ph = 1; ph <= 11; ph++) begin
      if (ph == 1) cfg_val = '{24'h7FFFFF, 24'h800000, 24'hFFFFFF, 24'd0, 24'd65535,
                               24'hFFFFFF, 24'h800000};
      else if (ph == 2) cfg_val = '{24'h800000, 24'h7FFFFF, 24'd0, 24'd65535, 24'd0,
                                    24'd0, 24'h7FFFFF};
      else if (ph == 3) cfg_val = '{24'd0, 24'd0, 24'd0, 24'd0, 24'd65535, 24'd0, 24'd1};
      else begin
        foreach (cfg_val[i]) cfg_val[i] = 24'($urandom);
        cfg_val[0] = (ph % 2) ? 24'($urandom_range(0, 20000) - 10000) : cfg_val[0];
        cfg_val[1] = (ph % 2) ? 24'($urandom_range(0, 20000) - 10000) : cfg_val[1];
        cfg_val[3] = 24'($urandom_range(0, 1500));
        cfg_val[4] = 24'($urandom_range(2000, 65535));
      end
      for (int r = 0; r < 7; r++) write_reg(r[lbmp_pkg::CfgIdxW-1:0], cfg_val[r]);
      no_idle = (ph % 4 == 3);
      if (ph == 5) hold_req++;
      queue_beat(pose_beat($urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
      for (int n = 0; n < 150; n++) begin
        lo = $urandom_range(0, 99);
        if (lo < 8) queue_beat(pose_beat($urandom, $urandom, $urandom, $urandom,
                                         $urandom, $urandom));
        else if (lo < 15) queue_beat(any_beat());
        else queue_beat(good_beam());
      end
      wait_drained();
    end

    if (n_errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/lbmp_pkg.sv
rtl/core/lbmp_ctrl.sv
rtl/core/lbmp_dp.sv
rtl/core/lidar_beam_to_map_point.sv
verif/testbench.sv
